// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    // Input opcodes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 7;

    // Per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'b00,
        CMD_INSERT = 2'b01,
        CMD_SHIFT  = 2'b10
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic [VALUE_W-1:0]        new_value;
        logic signed [PRIO_W-1:0]  new_prio;
    } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted shift-register queue: holds an entry and trades with its neighbors.
module spq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                              clk,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                  occupancy,
    input  logic                              left_keep,
    input  logic [spq_pkg::VALUE_W-1:0]       left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic [spq_pkg::VALUE_W-1:0]       right_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
    output logic                              keep,
    output logic [spq_pkg::VALUE_W-1:0]       value_q,
    output logic signed [spq_pkg::PRIO_W-1:0] prio_q
);
    import spq_pkg::*;

    logic [VALUE_W-1:0]       value_reg;
    logic [VALUE_W-1:0]       value_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic                     occupied;

    // Slot holds a live entry when it sits below the fill level
    assign occupied = CNT_W'(INDEX) < occupancy;

    // Entry stays put on insert when it ranks equal or higher than the new one
    assign keep = occupied && (prio_reg >= ctrl.new_prio);

    // Next entry: hold, take the new beat, take the left entry, or take the right entry
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        value_next = ctrl.new_value;
                        prio_next  = ctrl.new_prio;
                    end
                    else
                    begin
                        value_next = left_value;
                        prio_next  = left_prio;
                    end
                end
            end
            CMD_SHIFT:
            begin
                value_next = right_value;
                prio_next  = right_prio;
            end
            default:
            begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value_q = value_reg;
    assign prio_q  = prio_reg;

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a row of shift-register cells with an output register.
//
// Channel  Direction  Handshake             Fields
// in       input      in_valid / in_stall    opcode, value, priority_req
// out      output     out_valid / out_stall  status, value_out, count
//
// All cells compare against the new priority and shift in parallel, so a new beat is
// accepted each cycle while in_stall is low, and its result appears the next cycle.
// rst_n clears the fill level and the output valid; cell contents are not reset.
// in_stall is high only while a result sits in the output register and out_stall is high.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0] value,
    input  logic signed [spq_pkg::PRIO_W-1:0]  priority_req,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [spq_pkg::VALUE_W-1:0] value_out,
    output logic [spq_pkg::COUNT_W-1:0]        count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [VALUE_W-1:0]       value_out_reg;
    logic [VALUE_W-1:0]       value_out_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [EXT_W-1:0]         occ_ext;
    logic                     accept;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;

    // Neighbor links: slot 0 is the head boundary, slot CAPACITY+1 the tail boundary
    logic                     keep_chain  [CAPACITY+1];
    logic [VALUE_W-1:0]       value_chain [CAPACITY+2];
    logic signed [PRIO_W-1:0] prio_chain  [CAPACITY+2];

    // Handshake
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (occ_reg == CNT_W'(CAPACITY));
    assign empty    = (occ_reg == '0);

    // Command to the cells and the next fill level and result
    always_comb
    begin
        ctrl.cmd       = CMD_HOLD;
        ctrl.new_value = value;
        ctrl.new_prio  = priority_req;
        occ_next       = occ_reg;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        if (accept)
        begin
            value_out_next = '0;
            if (opcode == OP_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.cmd    = CMD_INSERT;
                    occ_next    = occ_reg + CNT_W'(1);
                    status_next = ST_INSERTED;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.cmd       = CMD_SHIFT;
                    occ_next       = occ_reg - CNT_W'(1);
                    status_next    = ST_DEQUEUED;
                    value_out_next = value_chain[1];
                end
            end
        end
    end

    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);
    assign occ_ext        = EXT_W'(occ_next);

    // Boundaries of the cell row
    assign keep_chain[0]           = 1'b1;
    assign value_chain[0]          = '0;
    assign prio_chain[0]           = '0;
    assign value_chain[CAPACITY+1] = '0;
    assign prio_chain[CAPACITY+1]  = '0;

    // Row of cells, head entry in cell 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupancy   (occ_reg),
            .left_keep   (keep_chain[i]),
            .left_value  (value_chain[i]),
            .left_prio   (prio_chain[i]),
            .right_value (value_chain[i+2]),
            .right_prio  (prio_chain[i+2]),
            .keep        (keep_chain[i+1]),
            .value_q     (value_chain[i+1]),
            .prio_q      (prio_chain[i+1])
        );
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            count_reg     <= occ_ext[COUNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign count     = count_reg;

endmodule
